>>> hw/rtl/rgb_to_hsl_converter_macros.svh
// Assertion macros shared by the RGB to HSL converter modules.
// Every macro expects clk and rst_n to be visible where it is used.
`ifndef RGB_TO_HSL_CONVERTER_MACROS_SVH
`define RGB_TO_HSL_CONVERTER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define RHC_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// An implication that must hold at every clock edge outside reset.
`define RHC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/rhc_pkg.sv
// Types, constants and the divider step function of the RGB to HSL converter.
// Depends on nothing; every RTL module imports it.
package rhc_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [8:0] hue_deg;
        logic [7:0] saturation;
        logic [7:0] lightness;
    } hsl_t;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    typedef struct packed {
        logic [7:0] rem;
        logic [7:0] low;
        logic [7:0] dvs;
    } div_t;

    typedef struct packed {
        div_t       sat;
        div_t       hue;
        logic       neg;
        sector_t    sector;
        logic       grey;
        logic [7:0] light;
    } pipe_t;

    localparam int unsigned DIV_STEPS = 8;

    localparam logic [9:0] CHAN_MAX   = 10'd255;
    localparam logic [9:0] OFFS_GREEN = 10'd120;
    localparam logic [9:0] OFFS_BLUE  = 10'd240;
    localparam logic [9:0] HUE_WRAP   = 10'd360;

    // One restoring division step: shifts one numerator bit into the
    // remainder and one quotient bit into the low byte.
    function automatic div_t div_step(input div_t d);
        logic [8:0] trial;
        div_t       r;
        trial = {d.rem, d.low[7]};
        r     = d;
        if (trial >= {1'b0, d.dvs})
        begin
            r.rem = 8'(trial - {1'b0, d.dvs});
            r.low = {d.low[6:0], 1'b1};
        end
        else
        begin
            r.rem = trial[7:0];
            r.low = {d.low[6:0], 1'b0};
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/rgb_to_hsl_converter.sv
// Top level of the RGB to HSL converter: front end, divider stages, back end.
// Depends on rhc_pkg, rhc_front, rhc_div_stage, rhc_back and the macros.
//
//   channel   signals                               carries
//   input     pixel_valid, pixel_ready, pixel       red, green, blue
//   output    hsl_valid, hsl_ready, hsl             hue_deg, saturation, lightness
//
// The pipeline holds two front-end stages, eight divider stages
// (one quotient bit each) and the output register.
// One pixel is accepted per cycle whenever the output register is free or drained.
// A stall freezes every stage at once, so nothing is lost or repeated.
// Reset clears only the valid bits.
`include "rgb_to_hsl_converter_macros.svh"

module rgb_to_hsl_converter (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pixel_valid,
    output logic          pixel_ready,
    input  rhc_pkg::rgb_t pixel,
    output logic          hsl_valid,
    input  logic          hsl_ready,
    output rhc_pkg::hsl_t hsl
);
    import rhc_pkg::*;

    logic  adv;
    logic  stage_valid [0:DIV_STEPS];
    pipe_t stage_data  [0:DIV_STEPS];

    assign adv         = !hsl_valid || hsl_ready;
    assign pixel_ready = adv;

    rhc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (pixel_valid),
        .in_pix    (pixel),
        .out_valid (stage_valid[0]),
        .out_data  (stage_data[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        rhc_div_stage u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (stage_valid[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i+1]),
            .out_data  (stage_data[i+1])
        );
    end

    rhc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (stage_valid[DIV_STEPS]),
        .in_data   (stage_data[DIV_STEPS]),
        .out_valid (hsl_valid),
        .out_pix   (hsl)
    );

    `RHC_ASSERT_IMPL(hue_in_range, hsl_valid, hsl.hue_deg < 9'd360, "hue out of range")
    `RHC_ASSERT_IMPL(grey_hue_zero, hsl_valid && hsl.saturation == 8'd0, hsl.hue_deg == 9'd0, "zero saturation with nonzero hue")

endmodule

>>> hw/rtl/rhc_front.sv
// Front end of the converter: max/min search, then numerators and divisors.
// Two register stages; depends on rhc_pkg and the assertion macros.
`include "rgb_to_hsl_converter_macros.svh"

module rhc_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  rhc_pkg::rgb_t in_pix,
    output logic          out_valid,
    output rhc_pkg::pipe_t out_data
);
    import rhc_pkg::*;

    logic       a_valid_reg;
    sector_t    a_sector_reg;
    logic [7:0] a_delta_reg;
    logic [8:0] a_sum_reg;
    logic [7:0] a_adiff_reg;
    logic       a_neg_reg;

    sector_t    a_sector_next;
    logic [7:0] a_max;
    logic [7:0] a_min;
    logic [8:0] a_diff;

    logic       b_valid_reg;
    pipe_t      b_data_reg;
    pipe_t      b_data_next;

    logic [9:0]  b_offs;
    logic [9:0]  b_dist;
    logic [9:0]  b_den;
    logic [15:0] b_nhue;
    logic [15:0] b_nsat;

    always_comb
    begin
        if (in_pix.red >= in_pix.green && in_pix.red >= in_pix.blue)
        begin
            a_sector_next = SECT_RED;
            a_max         = in_pix.red;
            a_diff        = {1'b0, in_pix.green} - {1'b0, in_pix.blue};
        end
        else if (in_pix.green >= in_pix.blue)
        begin
            a_sector_next = SECT_GREEN;
            a_max         = in_pix.green;
            a_diff        = {1'b0, in_pix.blue} - {1'b0, in_pix.red};
        end
        else
        begin
            a_sector_next = SECT_BLUE;
            a_max         = in_pix.blue;
            a_diff        = {1'b0, in_pix.red} - {1'b0, in_pix.green};
        end
        a_min = in_pix.red;
        if (in_pix.green < a_min)
        begin
            a_min = in_pix.green;
        end
        if (in_pix.blue < a_min)
        begin
            a_min = in_pix.blue;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_sector_reg <= a_sector_next;
            a_delta_reg  <= a_max - a_min;
            a_sum_reg    <= {1'b0, a_max} + {1'b0, a_min};
            a_neg_reg    <= a_diff[8];
            a_adiff_reg  <= a_diff[8] ? 8'(-a_diff) : a_diff[7:0];
        end
    end

    always_comb
    begin
        b_offs = {1'b0, a_sum_reg} - CHAN_MAX;
        b_dist = b_offs[9] ? 10'(-b_offs) : b_offs;
        b_den  = CHAN_MAX - b_dist;
        b_nhue = ({8'b0, a_adiff_reg} << 6) - ({8'b0, a_adiff_reg} << 2);
        b_nsat = {a_delta_reg, 8'b0} - {8'b0, a_delta_reg};

        b_data_next.sat.rem = b_nsat[15:8];
        b_data_next.sat.low = b_nsat[7:0];
        b_data_next.sat.dvs = b_den[7:0];
        b_data_next.hue.rem = b_nhue[15:8];
        b_data_next.hue.low = b_nhue[7:0];
        b_data_next.hue.dvs = a_delta_reg;
        b_data_next.neg     = a_neg_reg;
        b_data_next.sector  = a_sector_reg;
        b_data_next.grey    = (a_delta_reg == 8'd0);
        b_data_next.light   = a_sum_reg[8:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

    `RHC_ASSERT_IMPL(a_diff_bounded, a_valid_reg, a_adiff_reg <= a_delta_reg, "hue difference exceeds delta")
    `RHC_ASSERT_IMPL(b_den_covers, b_valid_reg, b_data_reg.sat.dvs >= b_data_reg.hue.dvs, "saturation divisor below delta")

endmodule

>>> hw/rtl/rhc_div_stage.sv
// One register stage of the two restoring dividers (saturation and hue).
// Depends on rhc_pkg and the assertion macros.
`include "rgb_to_hsl_converter_macros.svh"

module rhc_div_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  rhc_pkg::pipe_t in_data,
    output logic           out_valid,
    output rhc_pkg::pipe_t out_data
);
    import rhc_pkg::*;

    logic  valid_reg;
    pipe_t data_reg;
    pipe_t data_next;

    always_comb
    begin
        data_next     = in_data;
        data_next.sat = div_step(in_data.sat);
        data_next.hue = div_step(in_data.hue);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    `RHC_ASSERT_IMPL(sat_rem_below, valid_reg && !data_reg.grey, data_reg.sat.rem < data_reg.sat.dvs, "saturation remainder out of range")
    `RHC_ASSERT_IMPL(hue_rem_below, valid_reg && !data_reg.grey, data_reg.hue.rem < data_reg.hue.dvs, "hue remainder out of range")

endmodule

>>> hw/rtl/rhc_back.sv
// Back end of the converter: hue sign, offset and wrap, grey handling.
// Holds the output register; depends on rhc_pkg.
module rhc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  rhc_pkg::pipe_t in_data,
    output logic           out_valid,
    output rhc_pkg::hsl_t  out_pix
);
    import rhc_pkg::*;

    logic       valid_reg;
    hsl_t       pix_reg;
    hsl_t       pix_next;

    logic [9:0] mag;
    logic [9:0] frac;
    logic [9:0] hue;

    always_comb
    begin
        mag = {2'b0, in_data.hue.low};
        if (in_data.neg && in_data.hue.rem != 8'd0)
        begin
            mag = mag + 10'd1;
        end
        frac = in_data.neg ? 10'(-mag) : mag;
        unique case (in_data.sector)
            SECT_RED:   hue = frac[9] ? frac + HUE_WRAP : frac;
            SECT_GREEN: hue = frac + OFFS_GREEN;
            SECT_BLUE:  hue = frac + OFFS_BLUE;
            default:    hue = 10'd0;
        endcase

        pix_next.hue_deg    = in_data.grey ? 9'd0 : hue[8:0];
        pix_next.saturation = in_data.grey ? 8'd0 : in_data.sat.low;
        pix_next.lightness  = in_data.light;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;

endmodule

>>> verif/rgb_to_hsl_converter_tb.sv
// Self-checking testbench for rgb_to_hsl_converter: directed and random pixels
// are sent with random idling on both sides and every result is checked in order.
// Depends on rhc_pkg and the rgb_to_hsl_converter RTL.
module rgb_to_hsl_converter_tb;

    import rhc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PER_PHASE = 162;
    localparam int DRAIN_CYCLES = 16;

    typedef struct {
        rgb_t px;
        hsl_t want;
    } hsl_expectation_t;

    class hsl_scoreboard;
        hsl_expectation_t pending_hsl[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return pending_hsl.size();
        endfunction

        static function int floor_div(int num, int den);
            if (num >= 0)
            begin
                return num / den;
            end
            return -((-num + den - 1) / den);
        endfunction

        function hsl_t to_hsl(rgb_t p);
            int r;
            int g;
            int b;
            int hi;
            int lo;
            int span;
            int total;
            int den;
            int h;
            sector_t sect;
            hsl_t res;
            r = p.red;
            g = p.green;
            b = p.blue;
            hi = r;
            lo = r;
            sect = SECT_RED;
            if (g > hi)
            begin
                hi = g;
                sect = SECT_GREEN;
            end
            if (b > hi)
            begin
                hi = b;
                sect = SECT_BLUE;
            end
            if (g < lo)
            begin
                lo = g;
            end
            if (b < lo)
            begin
                lo = b;
            end
            span = hi - lo;
            total = hi + lo;
            res.lightness = 8'(total / 2);
            res.saturation = '0;
            res.hue_deg = '0;
            if (span > 0)
            begin
                den = 255 - ((total > 255) ? total - 255 : 255 - total);
                res.saturation = 8'((255 * span) / den);
                case (sect)
                    SECT_RED:
                    begin
                        h = floor_div(60 * (g - b), span);
                        if (h < 0)
                        begin
                            h += 360;
                        end
                    end
                    SECT_GREEN: h = 120 + floor_div(60 * (b - r), span);
                    default: h = 240 + floor_div(60 * (r - g), span);
                endcase
                res.hue_deg = 9'(h);
            end
            return res;
        endfunction

        function void note_pixel(rgb_t p);
            hsl_expectation_t e;
            e.px = p;
            e.want = to_hsl(p);
            pending_hsl.insert(pending_hsl.size(), e);
        endfunction

        task report(string what, int got, int want, rgb_t p);
            $display("hsl mismatch on %s for pixel r=%0d g=%0d b=%0d: got %0d, expected %0d",
                     what, p.red, p.green, p.blue, got, want);
            errors++;
        endtask

        task check_hsl(hsl_t got);
            hsl_expectation_t e;
            if (pending_hsl.size() == 0)
            begin
                report("unexpected transfer", got, 0, '0);
                return;
            end
            e = pending_hsl.pop_front();
            if (got.hue_deg !== e.want.hue_deg)
            begin
                report("hue_deg", got.hue_deg, e.want.hue_deg, e.px);
            end
            if (got.saturation !== e.want.saturation)
            begin
                report("saturation", got.saturation, e.want.saturation, e.px);
            end
            if (got.lightness !== e.want.lightness)
            begin
                report("lightness", got.lightness, e.want.lightness, e.px);
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic pixel_valid = 1'b0;
    logic pixel_ready;
    rgb_t pixel = '0;
    logic hsl_valid;
    logic hsl_ready = 1'b0;
    hsl_t hsl;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;
    hsl_scoreboard sb;

    rgb_to_hsl_converter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .hsl_valid   (hsl_valid),
        .hsl_ready   (hsl_ready),
        .hsl         (hsl)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        hsl_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_valid && pixel_ready)
            begin
                sb.note_pixel(pixel);
            end
            if (hsl_valid && hsl_ready)
            begin
                sb.check_hsl(hsl);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("rgb_to_hsl_converter regression: fail");
            $finish;
        end
    end

    task send_pixel(input rgb_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel <= p;
        @(posedge clk);
        while (!pixel_ready)
        begin
            @(posedge clk);
        end
    endtask

    task send_rgb(input int r, input int g, input int b);
        rgb_t p;
        p.red = 8'(r);
        p.green = 8'(g);
        p.blue = 8'(b);
        send_pixel(p);
    endtask

    // The last transfer is noted by the monitor at the same edge, so the task
    // lets the monitor record it before the pending count is trusted.
    task wait_for_drain();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic rgb_t random_pixel();
        rgb_t p;
        int top;
        int mid;
        int low;
        p.red = 8'($urandom);
        p.green = 8'($urandom);
        p.blue = 8'($urandom);
        top = $urandom_range(1, 255);
        low = $urandom_range(0, top - 1);
        case ($urandom_range(11))
            4: p = {3{8'($urandom)}};
            5: p = {8'(top), 8'(top), 8'(low)};
            6: p = {8'(low), 8'(top), 8'(top)};
            7: p = {8'(top), 8'(low), 8'(top)};
            8:
            begin
                p.red = ($urandom_range(1)) ? 8'hFF - 8'($urandom_range(1)) : 8'($urandom_range(1));
                p.green = ($urandom_range(1)) ? 8'hFF - 8'($urandom_range(1)) : 8'($urandom_range(1));
                p.blue = ($urandom_range(1)) ? 8'hFF - 8'($urandom_range(1)) : 8'($urandom_range(1));
            end
            9:
            begin
                mid = $urandom_range(2, 255);
                p.red = 8'(mid - $urandom_range(2));
                p.green = 8'(mid - $urandom_range(2));
                p.blue = 8'(mid - $urandom_range(2));
            end
            10:
            begin
                top = $urandom_range(2, 255);
                mid = $urandom_range(1, top);
                p.red = 8'(top);
                p.blue = 8'(mid);
                p.green = 8'($urandom_range(0, mid - 1));
            end
            default: ;
        endcase
        return p;
    endfunction

    initial
    begin
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_rgb(0, 0, 0);
        send_rgb(255, 255, 255);
        send_rgb(128, 128, 128);
        send_rgb(255, 0, 0);
        send_rgb(0, 255, 0);
        send_rgb(0, 0, 255);
        send_rgb(255, 0, 1);
        send_rgb(255, 1, 0);
        send_rgb(200, 10, 199);
        send_rgb(255, 255, 0);
        send_rgb(0, 255, 255);
        send_rgb(255, 0, 255);
        send_rgb(1, 0, 0);
        send_rgb(0, 0, 1);
        send_rgb(255, 254, 254);
        send_rgb(128, 127, 127);
        send_rgb(127, 128, 128);
        send_rgb(0, 1, 255);
        send_rgb(254, 255, 0);
        send_rgb(85, 170, 255);
        wait_for_drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 82;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 82;
                end
                default:
                begin
                    send_idle_pct = 19;
                    recv_stall_pct = 19;
                end
            endcase
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                send_pixel(random_pixel());
            end
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("rgb_to_hsl_converter regression: pass");
        end
        else
        begin
            $display("rgb_to_hsl_converter regression: fail");
        end
        $finish;
    end

endmodule
